// ===== rtl/core/rhdf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhdf_pkg
// Shared types for the recent-hash duplicate filter: the command word from
// the controller to the datapath, and the status word returned from it.
// ----------------------------------------------------------------------------
package rhdf_pkg;

  localparam int unsigned HashWidth = 64;

  typedef logic [HashWidth-1:0] hash_t;

  // Commands that the controller issues to the datapath.
  typedef struct packed {
    logic load;   // latch the hash and restart the scan
    logic issue;  // read the next ring entry
    logic write;  // record the hash at the write position
  } rhdf_cmd_t;

  // Status that the datapath returns to the controller.
  typedef struct packed {
    logic hit;         // the entry read last cycle equals the hash
    logic pending;     // a read result is waiting for its compare
    logic all_issued;  // every valid entry has been read
  } rhdf_status_t;

endpackage : rhdf_pkg
`default_nettype wire

// ===== rtl/core/rhdf_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhdf_datapath
// Ring memory, write position, fill count and the one-entry-per-cycle scan
// with its registered read and combinational compare.
// ----------------------------------------------------------------------------
module rhdf_datapath #(
  parameter int unsigned SLOTS_LOG2 = 7
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire rhdf_pkg::hash_t  hash_value,
  input  wire rhdf_pkg::rhdf_cmd_t    cmd,
  output rhdf_pkg::rhdf_status_t      status
);
  import rhdf_pkg::*;

  localparam int unsigned Depth = 1 << SLOTS_LOG2;

  hash_t                 ring [Depth];
  hash_t                 hash_reg;
  hash_t                 rd_data;
  logic                  rd_valid;
  logic [SLOTS_LOG2-1:0] wr_pos;
  logic [SLOTS_LOG2:0]   fill_cnt;
  logic [SLOTS_LOG2:0]   rd_idx;

  // Ring storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      ring[wr_pos] <= hash_reg;
    end
    if (cmd.issue) begin
      rd_data <= ring[rd_idx[SLOTS_LOG2-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hash_reg <= hash_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      rd_valid <= 1'b0;
    end else if (cmd.load) begin
      rd_idx   <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
      if (cmd.issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos   <= '0;
      fill_cnt <= '0;
    end else if (cmd.write) begin
      wr_pos <= wr_pos + 1'b1;
      if (fill_cnt != (SLOTS_LOG2+1)'(Depth)) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
    end
  end

  assign status.hit        = rd_valid && (rd_data == hash_reg);
  assign status.pending    = rd_valid;
  assign status.all_issued = (rd_idx == fill_cnt);

endmodule : rhdf_datapath
`default_nettype wire

// ===== rtl/core/rhdf_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhdf_controller
// Sequencer for one lookup: accept, scan the ring, then either report a
// duplicate or record the hash, and drive the result strobe.
// ----------------------------------------------------------------------------
module rhdf_controller (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire rhdf_pkg::rhdf_status_t  status,
  output rhdf_pkg::rhdf_cmd_t          cmd,
  output logic                         busy,
  output logic                         done,
  output logic                         already_seen
);
  import rhdf_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic state;
  logic state_next;
  logic done_next;
  logic seen_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    done_next  = 1'b0;
    seen_next  = already_seen;
    case (state)
      StIdle: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = StScan;
        end
      end
      StScan: begin
        if (status.hit) begin
          done_next  = 1'b1;
          seen_next  = 1'b1;
          state_next = StIdle;
        end else if (!status.all_issued) begin
          cmd.issue = 1'b1;
        end else if (!status.pending) begin
          cmd.write  = 1'b1;
          done_next  = 1'b1;
          seen_next  = 1'b0;
          state_next = StIdle;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    already_seen <= seen_next;
  end

  assign busy = (state != StIdle);

endmodule : rhdf_controller
`default_nettype wire

// ===== rtl/core/recent_hash_duplicate_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// recent_hash_duplicate_filter
// Checks each 64-bit hash against a ring of the most recently recorded
// hashes and records it when it is new.
// ----------------------------------------------------------------------------
// A word is accepted on a rising edge where start is high and busy is low.
// The hash is compared against the valid ring entries in turn, one entry per clock,
// through the ring's single registered read port; that scan sets the
// latency. With N valid entries (N saturates at 2^SLOTS_LOG2), a new hash
// raises done once all N entries have been compared (with no scan when the
// ring is still empty) with already_seen low, and it has then been written
// at the write position, the oldest slot once the ring is full. A duplicate
// is reported with already_seen high as soon as its match is compared, and
// the ring is left unchanged. The result is on already_seen in the cycle in
// which done is high; the receiver cannot hold it off, so it must capture
// it then. busy is already low in that same cycle, so the next word may be
// started there. The default ring holds 128 entries. No clearing pass is
// needed after reset: only entries inside the fill count are ever read.
// ----------------------------------------------------------------------------
module recent_hash_duplicate_filter #(
  parameter int unsigned SLOTS_LOG2 = 7
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  wire rhdf_pkg::hash_t  hash_value,
  output logic                  done,
  output logic                  already_seen
);
  import rhdf_pkg::*;

  rhdf_cmd_t    cmd;
  rhdf_status_t status;

  // The controller sequences each lookup and owns the result registers.
  rhdf_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .done         (done),
    .already_seen (already_seen)
  );

  // The datapath holds the ring, its write position and fill count.
  rhdf_datapath #(
    .SLOTS_LOG2 (SLOTS_LOG2)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .hash_value (hash_value),
    .cmd        (cmd),
    .status     (status)
  );

`ifndef SYNTHESIS
  // An accepted word always occupies the block on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  // The result strobe appears only once the block has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Every lookup ends with exactly one result strobe; it is never held high.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");
`endif

endmodule : recent_hash_duplicate_filter
`default_nettype wire
